>>> hw/rtl/mvzm_pkg.sv
`timescale 1ns / 1ps
package mvzm_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 3'd0,
    CFG_SHADOW_MIN  = 3'd1,
    CFG_SHADOW_MAX  = 3'd2,
    CFG_UMBRA       = 3'd3,
    CFG_PENUMBRA    = 3'd4,
    CFG_REVEAL_MODE = 3'd5,
    CFG_BYPASS      = 3'd6
  } cfg_idx_t;

  // register reset values
  localparam logic [6:0] THRESHOLD_RST  = 7'd64;
  localparam logic [6:0] SHADOW_MIN_RST = 7'd30;
  localparam logic [6:0] SHADOW_MAX_RST = 7'd90;
  localparam logic [9:0] UMBRA_RST      = 10'd500;
  localparam logic [9:0] PENUMBRA_RST   = 10'd500;

  // fixed point
  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [9:0]  DEPTH_MAX = 10'd1000;
  // reciprocals: floor(y/125) for y < 2^17 and floor(y/5) for y < 2^19, exact
  localparam logic [34:0] RECIP_125 = 35'd134218;
  localparam logic [37:0] RECIP_5   = 38'd419431;
  // 32768 = 5*6553 + 3, so floor(h*32768/5) = h*6553 + floor(3h/5)
  localparam logic [19:0] BAND_MUL  = 20'd6553;
  localparam logic [16:0] RECIP_5_S = 17'd205;

  localparam logic [3:0] NOTE_ON_NIBBLE = 4'h9;

  // pipeline
  localparam int DIV_STEPS  = 17;
  localparam int PIPE_DEPTH = DIV_STEPS + 8;

  typedef struct packed {
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [15:0] time_offset;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  out_status;
    logic [6:0]  out_first;
    logic [6:0]  out_second;
    logic [15:0] out_time;
  } out_res_t;

  typedef enum logic [1:0] {
    ACT_PASS  = 2'd0,
    ACT_DROP  = 2'd1,
    ACT_SCALE = 2'd2
  } act_t;

  // depth in tenths of a percent to Q16: floor(min(x,1000) * 65536 / 1000)
  function automatic logic [16:0] depth_q16(input logic [9:0] tenths);
    logic [9:0]  sat;
    logic [16:0] y;
    logic [34:0] prod;
    sat  = (tenths > DEPTH_MAX) ? DEPTH_MAX : tenths;
    y    = {7'd0, sat} * 17'd67;
    prod = {18'd0, y} * RECIP_125;
    return ({7'd0, sat} * 17'd65) + {6'd0, prod[34:24]};
  endfunction

  // floor(4u/5)
  function automatic logic [16:0] four_fifths(input logic [16:0] u);
    logic [18:0] y;
    logic [37:0] prod;
    y    = {u, 2'b00};
    prod = {19'd0, y} * RECIP_5;
    return prod[37:21];
  endfunction

endpackage

>>> hw/rtl/midi_velocity_zone_mask.sv
`timescale 1ns / 1ps
// Velocity zone mask for MIDI note-on requests. A request is taken on any
// cycle with start high and busy low; busy is high only while rst_n is
// asserted, so one request per cycle is sustained. Every request goes through
// a pipeline of registered stages: the result, if any, shows on out_res with
// out_valid high for exactly one cycle, in request order. The receiver cannot
// stall the block and must take each strobe as it comes. The pipeline is made
// up of the two 17-stage restoring dividers (zone distance and edge position),
// which run side by side, plus the input, decode and edge band stages, three
// multiply stages around one add stage, and the output register.
// Configuration writes are registered and must only be issued while no
// request is in flight.
module midi_velocity_zone_mask (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  mvzm_pkg::in_req_t                  in_req,
  output logic                               busy,
  output logic                               out_valid,
  output mvzm_pkg::out_res_t                 out_res,
  input  logic                               cfg_we,
  input  logic [mvzm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [mvzm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mvzm_pkg::*;

  typedef struct packed {
    in_req_t     req;
    act_t        act;
    logic        edge_on;
    logic [6:0]  h;     // half width in half-velocity units
    logic [19:0] band;  // edge band, Q16
    logic [6:0]  dr;    // distance divider remainder
    logic [16:0] dq;    // distance quotient
    logic [19:0] pr;    // edge position remainder
    logic [16:0] pq;    // edge position quotient
  } div_st_t;

  // ---------------------------------------------------------------------
  // configuration registers
  logic [6:0] threshold_r, shadow_min_r, shadow_max_r;
  logic [9:0] umbra_r, penumbra_r;
  logic       reveal_r, bypass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RST;
      shadow_min_r <= SHADOW_MIN_RST;
      shadow_max_r <= SHADOW_MAX_RST;
      umbra_r      <= UMBRA_RST;
      penumbra_r   <= PENUMBRA_RST;
      reveal_r     <= 1'b0;
      bypass_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_THRESHOLD:   threshold_r  <= cfg_wdata[6:0];
        CFG_SHADOW_MIN:  shadow_min_r <= cfg_wdata[6:0];
        CFG_SHADOW_MAX:  shadow_max_r <= cfg_wdata[6:0];
        CFG_UMBRA:       umbra_r      <= cfg_wdata;
        CFG_PENUMBRA:    penumbra_r   <= cfg_wdata;
        CFG_REVEAL_MODE: reveal_r     <= cfg_wdata[0];
        CFG_BYPASS:      bypass_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // derived depths; only read far down the pipe, so the extra cycles are safe
  logic [16:0] u_r, p_r, hfade_r;
  logic        hide_drop_r;

  always_ff @(posedge clk) begin
    u_r         <= depth_q16(umbra_r);
    p_r         <= depth_q16(penumbra_r);
    hfade_r     <= ONE_Q16 - four_fifths(u_r);
    hide_drop_r <= ({4'd0, hfade_r} * 21'd10) <= {4'd0, ONE_Q16};
  end

  // ---------------------------------------------------------------------
  // input stage
  assign busy = ~rst_n;

  logic    p1_vld_r;
  in_req_t p1_req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    p1_req_r <= in_req;
  end

  // ---------------------------------------------------------------------
  // decode: note-on test, zone ends in half-velocity units, action
  logic       note_on, aff;
  logic [6:0] span, hw_h, d1_dr_nxt;
  logic [7:0] t2, v2, lo2, hi2, diff2;
  logic [8:0] hi_sum;
  act_t       d1_act_nxt;

  always_comb begin
    note_on = (p1_req_r.status_byte[7:4] == NOTE_ON_NIBBLE) &&
              (p1_req_r.second_data != 7'd0);
    span    = (shadow_max_r >= shadow_min_r) ? (shadow_max_r - shadow_min_r)
                                             : (shadow_min_r - shadow_max_r);
    hw_h    = (span < 7'd2) ? 7'd2 : span;
    t2      = {threshold_r, 1'b0};
    v2      = {p1_req_r.second_data, 1'b0};
    lo2     = (t2 > {1'b0, hw_h}) ? (t2 - {1'b0, hw_h}) : 8'd0;
    hi_sum  = {1'b0, t2} + {2'b00, hw_h};
    hi2     = (hi_sum > 9'd254) ? 8'd254 : hi_sum[7:0];
    aff     = (v2 >= lo2) && (v2 <= hi2) && (p1_req_r.second_data >= threshold_r);
    diff2   = v2 - t2;
    // twice the distance never exceeds the half width inside the zone
    d1_dr_nxt = aff ? diff2[6:0] : 7'd0;

    if (bypass_r || !note_on) begin
      d1_act_nxt = ACT_PASS;
    end else if (reveal_r) begin
      d1_act_nxt = aff ? ACT_SCALE : ACT_DROP;
    end else begin
      d1_act_nxt = aff ? ACT_SCALE : ACT_PASS;
    end
  end

  logic       d1_vld_r;
  in_req_t    d1_req_r;
  act_t       d1_act_r;
  logic [6:0] d1_h_r, d1_dr_r;
  logic [7:0] d1_lo2_r, d1_hi2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
    end else begin
      d1_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_req_r <= p1_req_r;
    d1_act_r <= d1_act_nxt;
    d1_h_r   <= hw_h;
    d1_dr_r  <= d1_dr_nxt;
    d1_lo2_r <= lo2;
    d1_hi2_r <= hi2;
  end

  // ---------------------------------------------------------------------
  // edge band and edge position numerator
  logic [8:0]  h3;
  logic [16:0] h3x205;
  logic [19:0] band, num;
  logic [7:0]  v2b, mlo, mhi;
  logic [22:0] nlo, nhi;
  logic        edge_lo, edge_hi;
  div_st_t     d2_nxt;

  always_comb begin
    h3      = {2'b00, d1_h_r} + {1'b0, d1_h_r, 1'b0};
    h3x205  = {8'd0, h3} * RECIP_5_S;
    band    = ({13'd0, d1_h_r} * BAND_MUL) + {13'd0, h3x205[16:10]};
    v2b     = {d1_req_r.second_data, 1'b0};
    mlo     = v2b - d1_lo2_r;
    mhi     = d1_hi2_r - v2b;
    nlo     = {mlo, 15'd0};
    nhi     = {mhi, 15'd0};
    edge_lo = nlo < {3'd0, band};
    edge_hi = !edge_lo && (nhi < {3'd0, band});
    // numerator is kept below the band, so the position is a pure fraction
    if (edge_lo) begin
      num = nlo[19:0];
    end else if (edge_hi) begin
      num = nhi[19:0];
    end else begin
      num = 20'd0;
    end

    d2_nxt.req     = d1_req_r;
    d2_nxt.act     = d1_act_r;
    d2_nxt.edge_on = edge_lo | edge_hi;
    d2_nxt.h       = d1_h_r;
    d2_nxt.band    = band;
    d2_nxt.dr      = d1_dr_r;
    d2_nxt.dq      = 17'd0;
    d2_nxt.pr      = num;
    d2_nxt.pq      = 17'd0;
  end

  div_st_t dv_st_r  [DIV_STEPS+1];
  logic    dv_vld_r [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= d1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dv_st_r[0] <= d2_nxt;
  end

  // ---------------------------------------------------------------------
  // restoring dividers, one quotient bit per stage; first step is the
  // integer bit, the rest are fraction bits
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [7:0]  dsh;
    logic [20:0] psh;
    logic [7:0]  dsub;
    logic [20:0] psub;
    logic        dbit, pbit;
    div_st_t     st_nxt;

    always_comb begin
      st_nxt = dv_st_r[k];
      if (k == 0) begin
        dsh = {1'b0, dv_st_r[k].dr};
        psh = {1'b0, dv_st_r[k].pr};
      end else begin
        dsh = {dv_st_r[k].dr, 1'b0};
        psh = {dv_st_r[k].pr, 1'b0};
      end
      dsub      = dsh - {1'b0, dv_st_r[k].h};
      psub      = psh - {1'b0, dv_st_r[k].band};
      dbit      = dsh >= {1'b0, dv_st_r[k].h};
      pbit      = psh >= {1'b0, dv_st_r[k].band};
      st_nxt.dr = dbit ? dsub[6:0] : dsh[6:0];
      st_nxt.pr = pbit ? psub[19:0] : psh[19:0];
      st_nxt.dq = {dv_st_r[k].dq[15:0], dbit};
      st_nxt.pq = {dv_st_r[k].pq[15:0], pbit};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_st_r[k+1] <= st_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // E1: core and edge products
  logic        e1_vld_r;
  in_req_t     e1_req_r;
  act_t        e1_act_r;
  logic        e1_edge_r;
  logic [33:0] e1_cmul_r;
  logic [32:0] e1_emul_r;
  logic [16:0] one_m_dist;

  assign one_m_dist = ONE_Q16 - dv_st_r[DIV_STEPS].dq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
    end else begin
      e1_vld_r <= dv_vld_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    e1_req_r  <= dv_st_r[DIV_STEPS].req;
    e1_act_r  <= dv_st_r[DIV_STEPS].act;
    e1_edge_r <= dv_st_r[DIV_STEPS].edge_on;
    e1_cmul_r <= {17'd0, u_r} * {17'd0, one_m_dist};
    e1_emul_r <= {17'd0, dv_st_r[DIV_STEPS].pq[15:0]} * {16'd0, p_r};
  end

  // E2: core and edge fades
  logic        e2_vld_r;
  in_req_t     e2_req_r;
  act_t        e2_act_r;
  logic [16:0] e2_core_r, e2_edge_r;
  logic [16:0] core_nxt, edge_nxt;

  always_comb begin
    core_nxt = ONE_Q16 - e1_cmul_r[32:16];
    edge_nxt = e1_edge_r ? ({1'b0, e1_emul_r[31:16]} + (ONE_Q16 - p_r)) : ONE_Q16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_vld_r <= 1'b0;
    end else begin
      e2_vld_r <= e1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e2_req_r  <= e1_req_r;
    e2_act_r  <= e1_act_r;
    e2_core_r <= core_nxt;
    e2_edge_r <= edge_nxt;
  end

  // E3: combined reveal fade
  logic        e3_vld_r;
  in_req_t     e3_req_r;
  act_t        e3_act_r;
  logic [33:0] e3_fmul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3_vld_r <= 1'b0;
    end else begin
      e3_vld_r <= e2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e3_req_r  <= e2_req_r;
    e3_act_r  <= e2_act_r;
    e3_fmul_r <= {17'd0, e2_core_r} * {17'd0, e2_edge_r};
  end

  // E4: velocity times fade
  logic        e4_vld_r;
  in_req_t     e4_req_r;
  act_t        e4_act_r;
  logic [23:0] e4_vmul_r;
  logic [16:0] fade;

  assign fade = reveal_r ? e3_fmul_r[32:16] : hfade_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e4_vld_r <= 1'b0;
    end else begin
      e4_vld_r <= e3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e4_req_r  <= e3_req_r;
    e4_act_r  <= e3_act_r;
    e4_vmul_r <= {17'd0, e3_req_r.second_data} * {7'd0, fade};
  end

  // ---------------------------------------------------------------------
  // output register: clamp, drop decision
  logic       out_valid_r;
  out_res_t   out_res_r;
  logic [7:0] nv_raw;
  logic [6:0] nv;
  logic       keep;

  always_comb begin
    nv_raw = e4_vmul_r[23:16];
    if (nv_raw == 8'd0) begin
      nv = 7'd1;
    end else if (nv_raw > 8'd127) begin
      nv = 7'd127;
    end else begin
      nv = nv_raw[6:0];
    end
    // hide mode drops a note whose fade is no more than a tenth
    keep = (e4_act_r == ACT_PASS) ||
           ((e4_act_r == ACT_SCALE) && (reveal_r || !hide_drop_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= e4_vld_r & keep;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r.out_status <= e4_req_r.status_byte;
    out_res_r.out_first  <= e4_req_r.first_data;
    out_res_r.out_second <= (e4_act_r == ACT_SCALE) ? nv : e4_req_r.second_data;
    out_res_r.out_time   <= e4_req_r.time_offset;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> hw/rtl/mvzm_checker.sv
`timescale 1ns / 1ps
module mvzm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input mvzm_pkg::in_req_t  in_req,
  input logic               busy,
  input logic               out_valid,
  input mvzm_pkg::out_res_t out_res
);
  import mvzm_pkg::*;

  // history of accepted requests, aligned to the pipeline latency
  logic [PIPE_DEPTH-1:0] acc_hist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_hist_r <= '0;
    end else begin
      acc_hist_r <= {acc_hist_r[PIPE_DEPTH-2:0], start & ~busy};
    end
  end

  // a result only ever follows a request taken one latency earlier
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> acc_hist_r[PIPE_DEPTH-1])
    else $error("result without a matching request");

  // status, note and sample position come through untouched
  a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_res.out_status == $past(in_req.status_byte, PIPE_DEPTH)) &&
      (out_res.out_first  == $past(in_req.first_data, PIPE_DEPTH)) &&
      (out_res.out_time   == $past(in_req.time_offset, PIPE_DEPTH)))
    else $error("pass-through fields corrupted");

  // anything that is not a note-on comes out unchanged
  a_non_note: assert property (@(posedge clk) disable iff (!rst_n)
    acc_hist_r[PIPE_DEPTH-1] &&
    ($past(in_req.status_byte[7:4], PIPE_DEPTH) != NOTE_ON_NIBBLE) |->
      out_valid && (out_res.out_second == $past(in_req.second_data, PIPE_DEPTH)))
    else $error("non-note request lost or altered");

endmodule

bind midi_velocity_zone_mask mvzm_checker u_mvzm_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mvzm_pkg::*;

  localparam longint UNITY = 65536;
  localparam int PHASE_ITEMS = 108;
  localparam int STALL_LIMIT = 2000;

  // Expected-message store and velocity predictor
  class zone_mask_board;
    logic [6:0] thr, smin, smax;
    logic [9:0] umb, pen;
    bit reveal, byp;
    out_res_t pending_msgs[$];
    int n_req, n_res, n_masked, n_errors;

    function new();
      thr = THRESHOLD_RST;
      smin = SHADOW_MIN_RST;
      smax = SHADOW_MAX_RST;
      umb = UMBRA_RST;
      pen = PENUMBRA_RST;
      reveal = 1'b0;
      byp = 1'b0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [9:0] val);
      case (idx)
        CFG_THRESHOLD:   thr = val[6:0];
        CFG_SHADOW_MIN:  smin = val[6:0];
        CFG_SHADOW_MAX:  smax = val[6:0];
        CFG_UMBRA:       umb = val;
        CFG_PENUMBRA:    pen = val;
        CFG_REVEAL_MODE: reveal = val[0];
        CFG_BYPASS:      byp = val[0];
        default: ;
      endcase
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    // tenths of a percent to Q16, saturating at 1000
    function longint depth(logic [9:0] tenths);
      longint t;
      t = longint'(tenths);
      if (t > 1000) t = 1000;
      return (t * UNITY) / 1000;
    endfunction

    // Returns 1 when a message goes out; vel is its velocity byte
    function bit zone_velocity(in_req_t r, output logic [6:0] vel);
      longint v, vq, tq, span, hw, lo, hi, u, p, fade, nv, dist_q, edge_gain, band, pos;
      bit in_zone;
      vel = r.second_data;
      if (byp || r.status_byte[7:4] != NOTE_ON_NIBBLE || r.second_data == 7'd0)
        return 1'b1;
      v = longint'(r.second_data);
      vq = v * UNITY;
      tq = longint'(thr) * UNITY;
      span = longint'(smax) - longint'(smin);
      if (span < 0) span = -span;
      hw = span * (UNITY / 2);
      if (hw < UNITY) hw = UNITY;
      lo = clip(tq - hw, 0, 127 * UNITY);
      hi = clip(tq + hw, 0, 127 * UNITY);
      in_zone = (vq >= lo) && (vq <= hi);
      u = depth(umb);
      p = depth(pen);
      if (reveal) begin
        if (!in_zone || vq < tq) return 1'b0;
        dist_q = ((vq - tq) * UNITY) / hw;
        fade = UNITY - (u * (UNITY - dist_q)) / UNITY;
        edge_gain = UNITY;
        band = hw / 5;
        // fade toward either zone end
        if (vq < lo + band) begin
          pos = ((vq - lo) * UNITY) / band;
          edge_gain = (pos * p) / UNITY + UNITY - p;
        end else if (vq > hi - band) begin
          pos = ((hi - vq) * UNITY) / band;
          edge_gain = (pos * p) / UNITY + UNITY - p;
        end
        fade = (fade * edge_gain) / UNITY;
      end else begin
        if (!in_zone || vq < tq) return 1'b1;
        fade = UNITY - (u * 4) / 5;
        if (fade * 10 <= UNITY) return 1'b0;
      end
      nv = clip((v * fade) / UNITY, 1, 127);
      vel = nv[6:0];
      return 1'b1;
    endfunction

    function void note_request(in_req_t r);
      logic [6:0] vel;
      out_res_t m;
      n_req++;
      if (zone_velocity(r, vel)) begin
        m.out_status = r.status_byte;
        m.out_first = r.first_data;
        m.out_second = vel;
        m.out_time = r.time_offset;
        pending_msgs.insert(pending_msgs.size(), m);
      end else begin
        n_masked++;
      end
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      n_res++;
      if (pending_msgs.size() == 0) begin
        $error("unexpected message: status %h first %h second %h time %h",
               got.out_status, got.out_first, got.out_second, got.out_time);
        n_errors++;
        return;
      end
      want = pending_msgs.pop_front();
      if (got.out_status !== want.out_status) begin
        $error("out_status: expected %h, got %h", want.out_status, got.out_status);
        n_errors++;
      end
      if (got.out_first !== want.out_first) begin
        $error("out_first: expected %h, got %h", want.out_first, got.out_first);
        n_errors++;
      end
      if (got.out_second !== want.out_second) begin
        $error("out_second: expected %0d, got %0d", want.out_second, got.out_second);
        n_errors++;
      end
      if (got.out_time !== want.out_time) begin
        $error("out_time: expected %h, got %h", want.out_time, got.out_time);
        n_errors++;
      end
    endfunction

    function int outstanding();
      return pending_msgs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_req_t in_req = '0;
  logic busy;
  logic out_valid;
  out_res_t out_res;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  zone_mask_board board;
  int gap_mode;
  int n_settings;
  int stall_cycles;

  midi_velocity_zone_mask dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result monitor: every strobe is taken as it comes
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_res);
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $error("no request or result for %0d cycles", stall_cycles);
        $display("midi_velocity_zone_mask test failed");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    case (gap_mode)
      0: return 0;
      1: return $urandom_range(0, 15);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  function automatic in_req_t make_req(int st, int d1, int d2, int t);
    in_req_t r;
    r.status_byte = st[7:0];
    r.first_data = d1[6:0];
    r.second_data = d2[6:0];
    r.time_offset = t[15:0];
    return r;
  endfunction

  // mostly note-ons; half of all requests are aimed at the current zone
  function automatic in_req_t random_request();
    in_req_t r;
    int sel, half, c, span;
    r = in_req_t'({$urandom, $urandom});
    sel = $urandom_range(0, 9);
    if (sel <= 7) r.status_byte = {NOTE_ON_NIBBLE, r.status_byte[3:0]};
    if (sel < 5) begin
      span = int'(board.smax) - int'(board.smin);
      if (span < 0) span = -span;
      half = span / 2 + 3;
      c = int'(board.thr) + int'($urandom_range(0, 2 * half)) - half;
      if (c < 0) c = 0;
      if (c > 127) c = 127;
      r.second_data = c[6:0];
    end else if (sel == 7) begin
      r.second_data = 7'd0;
    end
    return r;
  endfunction

  // one request: optional idle gap, then hold start until taken
  task automatic push_request(in_req_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    board.note_request(r);
  endtask

  // let the pipeline empty, including requests that leave no message
  task automatic drain();
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  task automatic load_setting(int thr, int smin, int smax, int umb, int pen,
                              int rev, int byp);
    cfg_idx_t idx;
    int val;
    drain();
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        CFG_THRESHOLD:   val = thr;
        CFG_SHADOW_MIN:  val = smin;
        CFG_SHADOW_MAX:  val = smax;
        CFG_UMBRA:       val = umb;
        CFG_PENUMBRA:    val = pen;
        CFG_REVEAL_MODE: val = rev;
        default:         val = byp;
      endcase
      cfg_we <= 1'b1;
      cfg_idx <= idx;
      cfg_wdata <= val[CFG_DATA_W-1:0];
      @(posedge clk);
      board.write_reg(idx, val[CFG_DATA_W-1:0]);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // field extremes, non-note messages and the zone boundaries
  task automatic run_directed();
    int t, hwv, top, bot, above;
    t = int'(board.thr);
    hwv = (int'(board.smax) - int'(board.smin)) / 2;
    if (hwv < 0) hwv = -hwv;
    if (hwv < 1) hwv = 1;
    top = (t + hwv > 127) ? 127 : t + hwv;
    above = (top + 1 > 127) ? 127 : top + 1;
    bot = (t > 0) ? t - 1 : 0;
    gap_mode = 1;
    push_request(make_req(8'h90, 0, 127, 16'h0000));
    push_request(make_req(8'h9F, 127, 1, 16'hFFFF));
    push_request(make_req(8'h95, 60, 0, 1234));    // zero velocity
    push_request(make_req(8'h80, 64, 64, 0));      // note off
    push_request(make_req(8'hFF, 127, 127, 16'hFFFF));
    push_request(make_req(8'h00, 0, 0, 0));        // status below 0x80
    push_request(make_req(8'h7F, 127, 127, 16'h8000));
    push_request(make_req(8'h99, 33, t, 7));
    push_request(make_req(8'h9A, 1, bot, 8));
    push_request(make_req(8'h9B, 2, top, 9));
    push_request(make_req(8'h9C, 3, above, 10));
    push_request(make_req(8'h8F, 60, 100, 11));
    push_request(make_req(8'hA0, 60, 100, 12));
  endtask

  task automatic run_random(int n);
    gap_mode = $urandom_range(0, 2);
    repeat (n) push_request(random_request());
  endtask

  initial begin
    board = new();
    n_settings = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: hide mode
    run_directed();
    run_random(PHASE_ITEMS);

    // reveal with full depths
    load_setting(64, 30, 90, 1000, 1000, 1, 0);
    run_directed();
    run_random(PHASE_ITEMS);

    // corner settings: narrowest and widest zones, depth saturation, bypass
    load_setting(0, 10, 10, 0, 0, 1, 0);
    run_random(PHASE_ITEMS);
    load_setting(127, 0, 127, 1023, 1023, 1, 0);
    run_random(PHASE_ITEMS);
    load_setting(127, 127, 0, 1000, 0, 0, 0);
    run_random(PHASE_ITEMS);
    load_setting(0, 0, 127, 0, 1023, 0, 0);
    run_random(PHASE_ITEMS);
    load_setting(64, 64, 65, 1001, 500, 1, 0);
    run_random(PHASE_ITEMS);
    load_setting(100, 0, 127, 750, 250, 1, 1);
    run_random(PHASE_ITEMS);

    // random settings
    repeat (9) begin
      load_setting($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
                   $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1),
                   int'($urandom_range(0, 7) == 0));
      run_random(PHASE_ITEMS);
    end

    drain();
    if (board.outstanding() != 0) begin
      $error("%0d expected messages never arrived", board.outstanding());
    end
    $display("Covered %0d requests over %0d register settings (hide, reveal, bypass).",
             board.n_req, n_settings);
    $display("Checked %0d messages; %0d notes were masked out.", board.n_res, board.n_masked);
    if (board.n_errors == 0 && board.outstanding() == 0) begin
      $display("midi_velocity_zone_mask test passed");
    end else begin
      $display("midi_velocity_zone_mask test failed");
    end
    $finish;
  end

endmodule
